// ===== rtl/scancode_to_ascii_line_editor_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the scancode line editor.
// The macros expect signals named clk and rst in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef SCANCODE_TO_ASCII_LINE_EDITOR_MACROS_SVH
`define SCANCODE_TO_ASCII_LINE_EDITOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SC2A_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SC2A_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define SC2A_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sc2a_pkg.sv =====
// ----------------------------------------------------------------------------
// sc2a_pkg
// Shared types, constants and key tables of the scancode line editor.
// ----------------------------------------------------------------------------
`default_nettype none

package sc2a_pkg;

  localparam int CMD_W  = 2;
  localparam int SCAN_W = 8;
  localparam int IDX_W  = 8;
  localparam int KEY_W  = 7;
  localparam int LEN_W  = 8;

  localparam int LINE_DEPTH_DEF = 256;

  typedef enum logic [CMD_W-1:0] {
    CMD_SCAN  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  localparam logic [SCAN_W-1:0] REL_BIT   = 8'h80;
  localparam logic [SCAN_W-1:0] SC_LSHIFT = 8'h2A;
  localparam logic [SCAN_W-1:0] SC_RSHIFT = 8'h36;
  localparam logic [SCAN_W-1:0] SC_CAPS   = 8'h3A;
  localparam logic [SCAN_W-1:0] LAST_CODE = 8'd58;

  localparam logic [KEY_W-1:0] CH_NONE = 7'h00;
  localparam logic [KEY_W-1:0] CH_BS   = 7'h08;
  localparam logic [KEY_W-1:0] CH_NL   = 7'h0A;
  localparam logic [KEY_W-1:0] CH_LC_A = 7'h61;
  localparam logic [KEY_W-1:0] CH_LC_Z = 7'h7A;

  typedef struct packed {
    logic shift;
    logic caps;
  } key_state_t;

  function automatic logic [KEY_W-1:0] plain_char(input logic [5:0] code);
    logic [KEY_W-1:0] c;
    case (code)
      6'd1:  c = 7'h1B;
      6'd2:  c = 7'h31;
      6'd3:  c = 7'h32;
      6'd4:  c = 7'h33;
      6'd5:  c = 7'h34;
      6'd6:  c = 7'h35;
      6'd7:  c = 7'h36;
      6'd8:  c = 7'h37;
      6'd9:  c = 7'h38;
      6'd10: c = 7'h39;
      6'd11: c = 7'h30;
      6'd12: c = 7'h2D;
      6'd13: c = 7'h3D;
      6'd14: c = 7'h08;
      6'd15: c = 7'h09;
      6'd16: c = 7'h71;
      6'd17: c = 7'h77;
      6'd18: c = 7'h65;
      6'd19: c = 7'h72;
      6'd20: c = 7'h74;
      6'd21: c = 7'h79;
      6'd22: c = 7'h75;
      6'd23: c = 7'h69;
      6'd24: c = 7'h6F;
      6'd25: c = 7'h70;
      6'd26: c = 7'h5B;
      6'd27: c = 7'h5D;
      6'd28: c = 7'h0A;
      6'd30: c = 7'h61;
      6'd31: c = 7'h73;
      6'd32: c = 7'h64;
      6'd33: c = 7'h66;
      6'd34: c = 7'h67;
      6'd35: c = 7'h68;
      6'd36: c = 7'h6A;
      6'd37: c = 7'h6B;
      6'd38: c = 7'h6C;
      6'd39: c = 7'h3B;
      6'd40: c = 7'h27;
      6'd41: c = 7'h60;
      6'd43: c = 7'h5C;
      6'd44: c = 7'h7A;
      6'd45: c = 7'h78;
      6'd46: c = 7'h63;
      6'd47: c = 7'h76;
      6'd48: c = 7'h62;
      6'd49: c = 7'h6E;
      6'd50: c = 7'h6D;
      6'd51: c = 7'h2C;
      6'd52: c = 7'h2E;
      6'd53: c = 7'h2F;
      6'd55: c = 7'h2A;
      6'd57: c = 7'h20;
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [KEY_W-1:0] shifted_char(input logic [5:0] code);
    logic [KEY_W-1:0] c;
    case (code)
      6'd1:  c = 7'h1B;
      6'd2:  c = 7'h21;
      6'd3:  c = 7'h40;
      6'd4:  c = 7'h23;
      6'd5:  c = 7'h24;
      6'd6:  c = 7'h25;
      6'd7:  c = 7'h5E;
      6'd8:  c = 7'h26;
      6'd9:  c = 7'h2A;
      6'd10: c = 7'h28;
      6'd11: c = 7'h29;
      6'd12: c = 7'h5F;
      6'd13: c = 7'h2B;
      6'd14: c = 7'h08;
      6'd15: c = 7'h09;
      6'd16: c = 7'h51;
      6'd17: c = 7'h57;
      6'd18: c = 7'h45;
      6'd19: c = 7'h52;
      6'd20: c = 7'h54;
      6'd21: c = 7'h59;
      6'd22: c = 7'h55;
      6'd23: c = 7'h49;
      6'd24: c = 7'h4F;
      6'd25: c = 7'h50;
      6'd26: c = 7'h7B;
      6'd27: c = 7'h7D;
      6'd28: c = 7'h0A;
      6'd30: c = 7'h41;
      6'd31: c = 7'h53;
      6'd32: c = 7'h44;
      6'd33: c = 7'h46;
      6'd34: c = 7'h47;
      6'd35: c = 7'h48;
      6'd36: c = 7'h4A;
      6'd37: c = 7'h4B;
      6'd38: c = 7'h4C;
      6'd39: c = 7'h3A;
      6'd40: c = 7'h22;
      6'd41: c = 7'h7E;
      6'd43: c = 7'h7C;
      6'd44: c = 7'h5A;
      6'd45: c = 7'h58;
      6'd46: c = 7'h43;
      6'd47: c = 7'h56;
      6'd48: c = 7'h42;
      6'd49: c = 7'h4E;
      6'd50: c = 7'h4D;
      6'd51: c = 7'h3C;
      6'd52: c = 7'h3E;
      6'd53: c = 7'h3F;
      6'd55: c = 7'h2A;
      6'd57: c = 7'h20;
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sc2a_req_if.sv =====
// ----------------------------------------------------------------------------
// sc2a_req_if
// Command channel of the scancode line editor: valid/ready plus payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface sc2a_req_if;
  import sc2a_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [SCAN_W-1:0] scan_byte;
  logic [IDX_W-1:0]  read_index;

  modport source (output valid, cmd, scan_byte, read_index, input ready);
  modport sink   (input valid, cmd, scan_byte, read_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/sc2a_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sc2a_rsp_if
// Result channel of the scancode line editor: valid/ready plus payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface sc2a_rsp_if;
  import sc2a_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_char;
  logic             to_shell;
  logic             echo;
  logic             line_ready;
  logic [LEN_W-1:0] line_length;
  logic [KEY_W-1:0] read_data;

  modport source (output valid, key_char, to_shell, echo, line_ready, line_length,
                  read_data, input ready);
  modport sink   (input valid, key_char, to_shell, echo, line_ready, line_length,
                  read_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/sc2a_key_xlate.sv =====
// ----------------------------------------------------------------------------
// sc2a_key_xlate
// Maps a set-1 make code to ASCII using the shift and caps lock state.
// ----------------------------------------------------------------------------
`default_nettype none

module sc2a_key_xlate (
  input  wire logic [sc2a_pkg::SCAN_W-1:0] code,
  input  wire sc2a_pkg::key_state_t        kstate,
  output logic [sc2a_pkg::KEY_W-1:0]       key_char
);
  import sc2a_pkg::*;

  logic [KEY_W-1:0] lo_char;
  logic [KEY_W-1:0] up_char;
  logic             letter;
  logic             pick_upper;

  always_comb begin
    lo_char    = plain_char(code[5:0]);
    up_char    = shifted_char(code[5:0]);
    letter     = lo_char inside {[CH_LC_A:CH_LC_Z]};
    // Caps lock flips the shift sense, but only on letter keys.
    pick_upper = kstate.shift ^ (kstate.caps & letter);
    if (code > LAST_CODE) begin
      key_char = CH_NONE;
    end else if (pick_upper) begin
      key_char = up_char;
    end else begin
      key_char = lo_char;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/scancode_to_ascii_line_editor.sv =====
// ----------------------------------------------------------------------------
// scancode_to_ascii_line_editor
// Set-1 scancode translator with shell pass-through and a line editing buffer.
//
//   Channel  Kind       Transfer when          Carries
//   req      sink       req.valid & ready      cmd, scan_byte, read_index
//   rsp      source     rsp.valid & ready      key_char, to_shell, echo,
//                                              line_ready, line_length, read_data
//   cfg      write only cfg_we high            line_mode
//
// One command is taken per cycle while req.ready is high, and each gives one result
// after a first stage and the output register. The line buffer memory read data is
// registered once before the output register.
// Reset (synchronous, rst high) clears shift, caps lock, fill count, ready flag
// and line_mode; the buffer contents are left as they are.
// While rsp is stalled the block still takes one more command into its first
// stage, then holds req.ready low.
// ----------------------------------------------------------------------------
`default_nettype none

module scancode_to_ascii_line_editor #(
  parameter int LINE_DEPTH = sc2a_pkg::LINE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  sc2a_req_if.sink   req,
  sc2a_rsp_if.source rsp
);
  import sc2a_pkg::*;

  localparam int FILL_W = $clog2(LINE_DEPTH);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(LINE_DEPTH - 1);

  typedef struct packed {
    logic [KEY_W-1:0] key_char;
    logic             to_shell;
    logic             echo;
    logic             line_ready;
    logic [LEN_W-1:0] line_length;
    logic             hit;
  } stage_t;

  // Configuration and key state.
  logic              line_mode;
  key_state_t        kstate;
  key_state_t        kstate_next;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic              ready_flag;
  logic              ready_flag_next;
  logic              first_nl;
  logic              first_nl_next;

  // Line buffer.
  logic [KEY_W-1:0]  line_mem [LINE_DEPTH];
  logic [KEY_W-1:0]  mem_q;
  logic              wr_en;
  logic [FILL_W-1:0] rd_addr;

  // Pipeline.
  logic             accept;
  logic             s1_adv;
  logic             s1_valid;
  logic             s2_valid;
  stage_t           s1;
  stage_t           s1_next;
  logic [KEY_W-1:0] s2_read_data;
  stage_t           s2;

  logic [KEY_W-1:0] xl_char;
  logic             is_key;
  logic [KEY_W-1:0] ch;

  sc2a_key_xlate u_xlate (
    .code     (req.scan_byte),
    .kstate   (kstate),
    .key_char (xl_char)
  );

  assign s1_adv    = s1_valid && (!s2_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_adv;
  assign accept    = req.valid && req.ready;
  assign rd_addr   = req.read_index[FILL_W-1:0];

  always_comb begin
    kstate_next     = kstate;
    fill_next       = fill;
    ready_flag_next = ready_flag;
    first_nl_next   = first_nl;
    wr_en           = 1'b0;
    s1_next         = '0;
    is_key          = 1'b0;
    ch              = CH_NONE;

    case (req.cmd)
      CMD_SCAN: begin
        if ((req.scan_byte & REL_BIT) != '0) begin
          if ((req.scan_byte & ~REL_BIT) == SC_LSHIFT ||
              (req.scan_byte & ~REL_BIT) == SC_RSHIFT) begin
            kstate_next.shift = 1'b0;
          end
        end else if (req.scan_byte == SC_LSHIFT || req.scan_byte == SC_RSHIFT) begin
          kstate_next.shift = 1'b1;
        end else if (req.scan_byte == SC_CAPS) begin
          kstate_next.caps = ~kstate.caps;
        end else begin
          is_key = 1'b1;
        end

        if (is_key) begin
          ch = xl_char;
        end

        if (ch != CH_NONE) begin
          if (line_mode) begin
            if (ch == CH_BS) begin
              if (fill != '0) begin
                fill_next    = fill - 1'b1;
                s1_next.echo = 1'b1;
              end
            end else begin
              s1_next.echo = 1'b1;
              if (fill != FILL_MAX) begin
                wr_en     = 1'b1;
                fill_next = fill + 1'b1;
                if (fill == '0) begin
                  first_nl_next = (ch == CH_NL);
                end
              end
            end
            // A line that holds nothing but its newline is thrown away.
            if (ch == CH_NL) begin
              if (fill_next == FILL_W'(1) && first_nl_next) begin
                fill_next = '0;
              end else begin
                ready_flag_next = 1'b1;
              end
            end
          end else begin
            s1_next.to_shell = 1'b1;
          end
        end
      end
      CMD_READ: begin
        s1_next.hit = req.read_index < LEN_W'(fill);
      end
      CMD_CLEAR: begin
        fill_next       = '0;
        ready_flag_next = 1'b0;
      end
      default: begin
      end
    endcase

    s1_next.key_char    = ch;
    s1_next.line_ready  = ready_flag_next;
    s1_next.line_length = LEN_W'(fill_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_mode  <= 1'b0;
      kstate     <= '0;
      fill       <= '0;
      ready_flag <= 1'b0;
      first_nl   <= 1'b0;
    end else begin
      if (cfg_we) begin
        line_mode <= cfg_wdata;
      end
      if (accept) begin
        kstate     <= kstate_next;
        fill       <= fill_next;
        ready_flag <= ready_flag_next;
        first_nl   <= first_nl_next;
      end
    end
  end

  // Writes and reads come from different commands, so a read never sees a write from
  // its own command; any earlier write is already stored.
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      line_mem[fill] <= ch;
    end
    if (accept) begin
      mem_q <= line_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid <= 1'b1;
      end else if (rsp.ready) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
    if (s1_adv) begin
      s2           <= s1;
      s2_read_data <= s1.hit ? mem_q : CH_NONE;
    end
  end

  assign rsp.valid       = s2_valid;
  assign rsp.key_char    = s2.key_char;
  assign rsp.to_shell    = s2.to_shell;
  assign rsp.echo        = s2.echo;
  assign rsp.line_ready  = s2.line_ready;
  assign rsp.line_length = s2.line_length;
  assign rsp.read_data   = s2_read_data;

endmodule

`default_nettype wire

// ===== rtl/sc2a_checker.sv =====
// ----------------------------------------------------------------------------
// sc2a_checker
// Port-level checks on the result channel of the scancode line editor.
// ----------------------------------------------------------------------------
`default_nettype none

`include "scancode_to_ascii_line_editor_macros.svh"

module sc2a_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        rsp_valid,
  input wire logic                        rsp_ready,
  input wire logic [sc2a_pkg::KEY_W-1:0]  key_char,
  input wire logic                        to_shell,
  input wire logic                        echo,
  input wire logic [sc2a_pkg::KEY_W-1:0]  read_data
);
  import sc2a_pkg::*;

  // A stalled result keeps its character.
  `SC2A_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(key_char), "stalled result changed")

  // A character never goes to both the shell and the echo path.
  `SC2A_ASSERT_IMP(a_route_excl, rsp_valid, !(to_shell && echo), "shell and echo both set")

  // Shell and echo transfers always carry a character.
  `SC2A_ASSERT_IMP(a_route_char, rsp_valid && (to_shell || echo), key_char != CH_NONE, "routed empty char")

  // Only buffer reads return data, and those never carry a key character.
  `SC2A_ASSERT_IMP(a_read_excl, rsp_valid && (key_char != CH_NONE), read_data == CH_NONE, "read data on key result")

  // Nothing is offered in the cycle after reset.
  `SC2A_ASSERT_RST(a_reset_idle, rst, !rsp_valid, "result valid after reset")

endmodule

bind scancode_to_ascii_line_editor sc2a_checker u_sc2a_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .key_char  (rsp.key_char),
  .to_shell  (rsp.to_shell),
  .echo      (rsp.echo),
  .read_data (rsp.read_data)
);

`default_nettype wire
